// ----- sv/rsi_pkg.sv -----
package rsi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int PARAM_BITS      = 16;
  localparam int TOL_WIDTH       = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_AW        = 2;

endpackage

// ----- sv/rsi_if.sv -----
interface rsi_in_if #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
  input logic clk
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] seg_start_x;
  logic signed [COORD_WIDTH-1:0] seg_start_y;
  logic signed [COORD_WIDTH-1:0] seg_end_x;
  logic signed [COORD_WIDTH-1:0] seg_end_y;
  logic signed [COORD_WIDTH-1:0] ray_origin_x;
  logic signed [COORD_WIDTH-1:0] ray_origin_y;
  logic signed [COORD_WIDTH-1:0] ray_dir_x;
  logic signed [COORD_WIDTH-1:0] ray_dir_y;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    output ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    input  ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y,
    output ready
  );
endinterface

interface rsi_out_if #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
  input logic clk
);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic signed [COORD_WIDTH-1:0] hit_x;
  logic signed [COORD_WIDTH-1:0] hit_y;
  logic [rsi_pkg::PARAM_BITS:0]  seg_param;

  modport source (output valid, hit, hit_x, hit_y, seg_param, input ready);
  modport sink (input valid, hit, hit_x, hit_y, seg_param, output ready);
endinterface

// ----- sv/ray_segment_intersect_2d_unit.sv -----
// Ray against segment test in the plane, one word in and one word out per
// clock at full rate while out_ch.ready does not stall. A front pipeline of
// four stages forms the exact determinant and numerators and classifies the
// hit; a four-entry queue feeds a back pipeline of a seventeen-stage
// restoring divider for s and two interpolation stages. colinear_tolerance
// must be written through cfg_we/cfg_data while idle; nothing enforces it.
module ray_segment_intersect_2d_unit #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rsi_pkg::TOL_WIDTH-1:0] cfg_data,
  rsi_in_if.sink                        in_ch,
  rsi_out_if.source                     out_ch
);
  localparam int NW = 2 * COORD_WIDTH + 4;
  localparam int QW = 1 + 2 * NW + 2 * COORD_WIDTH + 2 * (COORD_WIDTH + 1);

  logic [rsi_pkg::TOL_WIDTH-1:0] tol;
  always_ff @(posedge clk) begin
    if (rst) tol <= '0;
    else if (cfg_we) tol <= cfg_data;
  end

  logic f_valid, f_ready, f_hit;
  logic [NW-1:0] f_det, f_ns;
  logic signed [COORD_WIDTH-1:0] f_x1, f_y1;
  logic signed [COORD_WIDTH:0] f_ex, f_ey;

  rsi_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst, .tol, .in_ch,
    .out_valid(f_valid), .out_ready(f_ready), .out_hit(f_hit),
    .out_det(f_det), .out_ns(f_ns), .out_x1(f_x1), .out_y1(f_y1),
    .out_ex(f_ex), .out_ey(f_ey)
  );

  logic q_valid, q_ready;
  logic [QW-1:0] q_data;

  rsi_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data({f_hit, f_det, f_ns, f_x1, f_y1, f_ex, f_ey}),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  logic b_hit;
  logic [NW-1:0] b_det, b_ns;
  logic signed [COORD_WIDTH-1:0] b_x1, b_y1;
  logic signed [COORD_WIDTH:0] b_ex, b_ey;
  assign {b_hit, b_det, b_ns, b_x1, b_y1, b_ex, b_ey} = q_data;

  rsi_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_hit(b_hit),
    .in_det(b_det), .in_ns(b_ns), .in_x1(b_x1), .in_y1(b_y1),
    .in_ex(b_ex), .in_ey(b_ey), .out_ch
  );
endmodule

// ----- sv/rsi_front.sv -----
// front: differences, exact products, sign fold and hit classification
module rsi_front #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [rsi_pkg::TOL_WIDTH-1:0]       tol,
  rsi_in_if.sink                              in_ch,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic [2*COORD_WIDTH+3:0]            out_det,
  output logic [2*COORD_WIDTH+3:0]            out_ns,
  output logic signed [COORD_WIDTH-1:0]       out_x1,
  output logic signed [COORD_WIDTH-1:0]       out_y1,
  output logic signed [COORD_WIDTH:0]         out_ex,
  output logic signed [COORD_WIDTH:0]         out_ey
);
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 2;

  // stage 1: differences
  logic              v1;
  logic signed [DW-1:0] ex1, ey1, wx1, wy1, dx1, dy1;
  logic signed [COORD_WIDTH-1:0] x11, y11;
  // stage 2: products
  logic              v2;
  logic signed [PW-1:0] p_dxey, p_dyex, p_dxwy, p_dywx, p_wyex, p_wxey;
  logic signed [DW-1:0] ex2, ey2;
  logic signed [COORD_WIDTH-1:0] x12, y12;
  // stage 3: numerators
  logic              v3;
  logic signed [NW-1:0] det3, ns3, nt3;
  logic signed [DW-1:0] ex3, ey3;
  logic signed [COORD_WIDTH-1:0] x13, y13;

  logic adv;
  logic signed [NW-1:0] det_a, ns_a, nt_a;
  logic neg;

  assign adv         = out_ready || !out_valid;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_comb begin
    neg   = det3[NW-1];
    det_a = neg ? -det3 : det3;
    ns_a  = neg ? -ns3 : ns3;
    nt_a  = neg ? -nt3 : nt3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex1 <= DW'(in_ch.seg_end_x) - DW'(in_ch.seg_start_x);
      ey1 <= DW'(in_ch.seg_end_y) - DW'(in_ch.seg_start_y);
      wx1 <= DW'(in_ch.ray_origin_x) - DW'(in_ch.seg_start_x);
      wy1 <= DW'(in_ch.ray_origin_y) - DW'(in_ch.seg_start_y);
      dx1 <= DW'(in_ch.ray_dir_x);
      dy1 <= DW'(in_ch.ray_dir_y);
      x11 <= in_ch.seg_start_x;
      y11 <= in_ch.seg_start_y;

      p_dxey <= PW'(dx1) * PW'(ey1);
      p_dyex <= PW'(dy1) * PW'(ex1);
      p_dxwy <= PW'(dx1) * PW'(wy1);
      p_dywx <= PW'(dy1) * PW'(wx1);
      p_wyex <= PW'(wy1) * PW'(ex1);
      p_wxey <= PW'(wx1) * PW'(ey1);
      ex2 <= ex1;
      ey2 <= ey1;
      x12 <= x11;
      y12 <= y11;

      det3 <= NW'(p_dxey) - NW'(p_dyex);
      ns3  <= NW'(p_dxwy) - NW'(p_dywx);
      nt3  <= NW'(p_wyex) - NW'(p_wxey);
      ex3 <= ex2;
      ey3 <= ey2;
      x13 <= x12;
      y13 <= y12;

      out_hit <= (det_a > NW'(tol)) && !ns_a[NW-1] && (ns_a <= det_a)
                 && !nt_a[NW-1] && (nt_a != '0);
      out_det <= det_a;
      out_ns  <= ns_a;
      out_x1  <= x13;
      out_y1  <= y13;
      out_ex  <= ex3;
      out_ey  <= ey3;
    end
  end
endmodule

// ----- sv/rsi_queue.sv -----
// small fifo between front and back
module rsi_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  localparam int AW = rsi_pkg::QUEUE_AW;
  logic [WIDTH-1:0] mem [rsi_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic wr, rd;

  assign wr_ready = cnt != (AW+1)'(rsi_pkg::QUEUE_DEPTH);
  assign rd_valid = cnt != '0;
  assign rd_data  = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end
endmodule

// ----- sv/rsi_back.sv -----
// back: pipelined restoring divide for s, then interpolation
module rsi_back #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_hit,
  input  logic [2*COORD_WIDTH+3:0]      in_det,
  input  logic [2*COORD_WIDTH+3:0]      in_ns,
  input  logic signed [COORD_WIDTH-1:0] in_x1,
  input  logic signed [COORD_WIDTH-1:0] in_y1,
  input  logic signed [COORD_WIDTH:0]   in_ex,
  input  logic signed [COORD_WIDTH:0]   in_ey,
  rsi_out_if.source                     out_ch
);
  localparam int PB = rsi_pkg::PARAM_BITS;
  localparam int NW = 2 * COORD_WIDTH + 4;
  localparam int DW = COORD_WIDTH + 1;
  localparam int ST = PB + 1;
  localparam int MW = DW + PB + 1;

  logic adv;
  logic            v   [ST+1];
  logic            h   [ST+1];
  logic [NW:0]     rem [ST+1];
  logic [NW-1:0]   dv  [ST+1];
  logic [PB:0]     q   [ST+1];
  logic signed [COORD_WIDTH-1:0] px [ST+1];
  logic signed [COORD_WIDTH-1:0] py [ST+1];
  logic signed [DW-1:0] qx [ST+1];
  logic signed [DW-1:0] qy [ST+1];

  logic       vm, hm;
  logic signed [MW-1:0] mx, my;
  logic signed [COORD_WIDTH-1:0] bx, by;
  logic [PB:0] qm;

  assign adv      = out_ch.ready || !out_ch.valid;
  assign in_ready = adv;

  assign v[0]   = in_valid;
  assign h[0]   = in_hit;
  assign rem[0] = {1'b0, in_ns};
  assign dv[0]  = in_det;
  assign q[0]   = '0;
  assign px[0]  = in_x1;
  assign py[0]  = in_y1;
  assign qx[0]  = in_ex;
  assign qy[0]  = in_ey;

  for (genvar i = 0; i < ST; i++) begin : g_div
    logic [NW:0] sh, df;
    logic        ge;
    always_comb begin
      sh = (i == 0) ? rem[i] : {rem[i][NW-1:0], 1'b0};
      df = sh - {1'b0, dv[i]};
      ge = !df[NW];
    end
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else if (adv) v[i+1] <= v[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        h[i+1]   <= h[i];
        rem[i+1] <= ge ? df : sh;
        dv[i+1]  <= dv[i];
        q[i+1]   <= {q[i][PB-1:0], ge};
        px[i+1]  <= px[i];
        py[i+1]  <= py[i];
        qx[i+1]  <= qx[i];
        qy[i+1]  <= qy[i];
      end
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else if (adv) vm <= v[ST];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      hm <= h[ST];
      qm <= q[ST];
      bx <= px[ST];
      by <= py[ST];
      mx <= MW'(qx[ST]) * $signed({1'b0, q[ST]});
      my <= MW'(qy[ST]) * $signed({1'b0, q[ST]});
    end
  end

  // output stage: truncate toward zero
  logic signed [MW-1:0] tx, ty;
  always_comb begin
    tx = mx[MW-1] ? -((-mx) >>> PB) : (mx >>> PB);
    ty = my[MW-1] ? -((-my) >>> PB) : (my >>> PB);
  end

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (adv) out_ch.valid <= vm;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.hit       <= hm;
      out_ch.hit_x     <= hm ? bx + COORD_WIDTH'(tx) : '0;
      out_ch.hit_y     <= hm ? by + COORD_WIDTH'(ty) : '0;
      out_ch.seg_param <= hm ? (PB+1)'((PB+1)'(1) << PB) - qm : '0;
    end
  end
endmodule

// ----- sv/rsi_checker.sv -----
module rsi_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [31:0] hit_x,
  input logic [31:0] hit_y,
  input logic [16:0] seg_param
);
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_x == '0 && hit_y == '0 && seg_param == '0)
    else $error("miss word not zero");
  a_param_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> seg_param <= 17'h10000)
    else $error("seg_param out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit))
    else $error("stalled word changed");
endmodule

bind ray_segment_intersect_2d_unit rsi_checker u_rsi_checker (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .hit(out_ch.hit), .hit_x(32'(out_ch.hit_x)), .hit_y(32'(out_ch.hit_y)),
  .seg_param(out_ch.seg_param)
);

// ----- tb/ray_segment_intersect_2d_unit_tb.sv -----
`timescale 1ns / 100ps

class rsi_scoreboard;
  typedef struct {
    logic        hit;
    logic [31:0] hx;
    logic [31:0] hy;
    logic [16:0] par;
  } hit_word_t;

  hit_word_t   pending_hits[$];
  logic [31:0] tolerance;
  int          mismatches;

  function new();
    tolerance = 0;
    mismatches = 0;
  endfunction

  function logic signed [31:0] lerp(logic signed [31:0] p, logic signed [32:0] e,
                                    logic [16:0] s16);
    logic signed [50:0] m;
    logic signed [50:0] q;
    begin
      m = e * $signed({1'b0, s16});
      q = (m < 0) ? -((-m) >>> 16) : (m >>> 16);
      lerp = p + q[31:0];
    end
  endfunction

  function void note_query(logic signed [31:0] x1, logic signed [31:0] y1,
                           logic signed [31:0] x2, logic signed [31:0] y2,
                           logic signed [31:0] ox, logic signed [31:0] oy,
                           logic signed [31:0] dx, logic signed [31:0] dy);
    logic signed [32:0] ex, ey, wx, wy;
    logic signed [69:0] det, ns, nt;
    logic [16:0] s16;
    hit_word_t w;
    int i;
    begin
      ex = x2 - x1;
      ey = y2 - y1;
      wx = ox - x1;
      wy = oy - y1;
      det = dx * ey - dy * ex;
      ns = dx * wy - dy * wx;
      nt = wy * ex - wx * ey;
      w = '{1'b0, 32'd0, 32'd0, 17'd0};
      if (det < 0) begin
        det = -det;
        ns = -ns;
        nt = -nt;
      end
      if (det > $signed({38'd0, tolerance}) && ns >= 0 && ns <= det && nt > 0) begin
        s16 = 0;
        if (ns >= det) begin
          s16 = 1;
          ns = ns - det;
        end
        for (i = 0; i < 16; i++) begin
          ns = ns <<< 1;
          s16 = s16 << 1;
          if (ns >= det) begin
            ns = ns - det;
            s16[0] = 1'b1;
          end
        end
        w.hit = 1'b1;
        w.hx = lerp(x1, ex, s16);
        w.hy = lerp(y1, ey, s16);
        w.par = 17'h10000 - s16;
      end
      pending_hits.push_back(w);
    end
  endfunction

  function void check_result(logic hit, logic [31:0] hx, logic [31:0] hy,
                             logic [16:0] par);
    hit_word_t w;
    begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word hit=%0b", hit);
      end else begin
        w = pending_hits.pop_front();
        if (w.hit !== hit || w.hx !== hx || w.hy !== hy || w.par !== par) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0b %h %h %h got %0b %h %h %h",
                     w.hit, w.hx, w.hy, w.par, hit, hx, hy, par);
        end
      end
    end
  endfunction
endclass

module ray_segment_intersect_2d_unit_tb;
  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_data;
  int          idle_cycles;
  int          long_stall;
  bit          sending_done;
  bit          timed_out;
  rsi_scoreboard sb;

  rsi_in_if  in_ch (.clk(clk));
  rsi_out_if out_ch (.clk(clk));

  ray_segment_intersect_2d_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: rand_coord = $urandom();
      1: rand_coord = $urandom_range(0, 3) == 0 ? 32'h7fffffff : 32'h80000000;
      2: rand_coord = $signed($urandom_range(0, 400)) - 200;
      default: rand_coord = ($signed($urandom_range(0, 2000)) - 1000) <<< 16;
    endcase
  endfunction

  task automatic send_query(input logic [31:0] x1, y1, x2, y2, ox, oy, dx, dy);
    int gap;
    begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.seg_start_x <= x1;
      in_ch.seg_start_y <= y1;
      in_ch.seg_end_x <= x2;
      in_ch.seg_end_y <= y2;
      in_ch.ray_origin_x <= ox;
      in_ch.ray_origin_y <= oy;
      in_ch.ray_dir_x <= dx;
      in_ch.ray_dir_y <= dy;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      sb.note_query(x1, y1, x2, y2, ox, oy, dx, dy);
    end
  endtask

  task automatic send_random(input int n);
    logic [31:0] x1, y1, x2, y2, ox, oy, dx, dy, sx, sy;
    begin
      repeat (n) begin
        x1 = rand_coord();
        y1 = rand_coord();
        x2 = rand_coord();
        y2 = rand_coord();
        ox = rand_coord();
        oy = rand_coord();
        if ($urandom_range(0, 2) != 0) begin
          // aim the ray at a point on the segment, or at times directly away from it
          sx = x1 + ($signed(x2 - x1) >>> 1);
          sy = y1 + ($signed(y2 - y1) >>> 1);
          dx = sx - ox;
          dy = sy - oy;
          if ($urandom_range(0, 3) == 0) begin
            dx = -dx;
            dy = -dy;
          end
        end else begin
          dx = rand_coord();
          dy = rand_coord();
        end
        send_query(x1, y1, x2, y2, ox, oy, dx, dy);
      end
    end
  endtask

  task automatic drain();
    begin
      in_ch.valid <= 1'b0;
      while (sb.pending_hits.size() != 0 && !timed_out) @(posedge clk);
      repeat (30) @(posedge clk);
    end
  endtask

  task automatic write_tolerance(input logic [31:0] v);
    begin
      cfg_we <= 1'b1;
      cfg_data <= v;
      @(posedge clk);
      cfg_we <= 1'b0;
      sb.tolerance = v;
      @(posedge clk);
    end
  endtask

  localparam logic [31:0] ONE = 32'h00010000;

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 0;
    long_stall = 0;
    sending_done = 0;
    in_ch.valid = 1'b0;
    in_ch.seg_start_x = 0;
    in_ch.seg_start_y = 0;
    in_ch.seg_end_x = 0;
    in_ch.seg_end_y = 0;
    in_ch.ray_origin_x = 0;
    in_ch.ray_origin_y = 0;
    in_ch.ray_dir_x = 0;
    in_ch.ray_dir_y = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_tolerance(32'd0);
    // plain crossing, endpoints, origin on segment, away, parallel, degenerate, extremes
    send_query(0, -ONE, 0, ONE, -ONE, 0, ONE, 0);
    send_query(0, 0, 0, ONE, -ONE, 0, ONE, 0);
    send_query(0, 0, 0, ONE, -ONE, ONE, ONE, 0);
    send_query(0, -ONE, 0, ONE, 0, 0, ONE, 0);
    send_query(0, -ONE, 0, ONE, -ONE, 0, -ONE, 0);
    send_query(0, -ONE, 0, ONE, -ONE, 0, 0, ONE);
    send_query(ONE, ONE, ONE, ONE, 0, 0, ONE, ONE);
    send_query(0, -ONE, 0, ONE, -ONE, 0, 0, 0);
    send_query(0, -ONE, 0, ONE, -ONE, 0, 1, 0);
    send_query(0, -ONE, 0, ONE, -ONE, 0, 32'h7fffffff, 32'h80000000);
    send_query(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
               32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_query(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
               32'h80000000, 32'h80000000, ONE, ONE);
    send_query(32'hffffffff, 0, 32'hffffffff, 32'h7fffffff,
               32'h80000000, 3, 32'hffffffff, 0);
    send_query(0, 0, 3 * ONE, ONE, ONE, -ONE, 1, 3);
    send_random(500);
    drain();
    write_tolerance(32'hffffffff);
    send_query(0, -ONE, 0, ONE, -ONE, 0, ONE, 0);
    send_random(300);
    drain();
    write_tolerance(32'h00010000);
    send_query(0, -1, 0, 1, -1, 0, 1, 0);
    send_random(300);
    long_stall = 300;
    send_random(200);
    drain();
    write_tolerance(32'h0000ffff);
    send_random(300);
    drain();
    write_tolerance(32'd0);
    send_random(250);
    in_ch.valid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (long_stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (long_stall) @(posedge clk);
        long_stall = 0;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      sb.check_result(out_ch.hit, out_ch.hit_x, out_ch.hit_y, out_ch.seg_param);
    end
  end

  initial begin
    timed_out = 0;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || cfg_we || rst)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > 2000) begin
        timed_out = 1;
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    wait (sending_done);
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
